// ----- design/reno_congestion_window_assert.svh -----
// Assertion macros for the Reno congestion window block
`ifndef RENO_CONGESTION_WINDOW_ASSERT_SVH
`define RENO_CONGESTION_WINDOW_ASSERT_SVH

// condition holds at every clock edge out of reset
`define RCW_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("rcw: invariant violated");

// same-cycle implication
`define RCW_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rcw: implication violated");

// next-cycle implication
`define RCW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rcw: next-cycle implication violated");

`endif

// ----- design/rcw_pkg.sv -----
// Shared constants, types and helpers for the Reno congestion window block
`default_nettype none
package rcw_pkg;
	localparam int IDX_W           = 16;
	localparam int BASE_W          = IDX_W + 1;
	localparam int WIN_W           = 11;
	localparam int THR_W           = 12;
	localparam int CFG_W           = 16;
	localparam int CFG_IDX_W       = 2;
	localparam int MAX_WINDOW      = 1024;
	localparam int THR_MAX         = 4095;
	localparam int START_THRESHOLD = 64;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [BASE_W-1:0] base_t;
	typedef logic [WIN_W-1:0]  win_t;
	typedef logic [THR_W-1:0]  thr_t;

	localparam win_t       MAX_WIN   = WIN_W'(MAX_WINDOW);
	localparam thr_t       START_THR = THR_W'(2 * START_THRESHOLD);
	localparam logic [1:0] DUP_LIMIT = 2'd3;

	localparam logic [1:0] CMD_SEND    = 2'd0;
	localparam logic [1:0] CMD_ACK     = 2'd1;
	localparam logic [1:0] CMD_TIMEOUT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_INIT_THRESH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FINAL_PACKET = CFG_IDX_W'(1);

	typedef struct packed {
		win_t window;
		win_t avoid;
		logic use_avoid;
	} step_req_t;

	typedef struct packed {
		win_t window;
		win_t avoid;
	} step_rsp_t;

	function automatic thr_t halve_window(input win_t w);
		if (int'(w) > THR_MAX) begin
			return THR_W'(THR_MAX);
		end
		return THR_W'(w);
	endfunction
endpackage
`default_nettype wire

// ----- design/rcw_event_if.sv -----
// Event channel: command and acknowledged index
`default_nettype none
interface rcw_event_if;
	import rcw_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	idx_t       ack_index;

	modport source (output valid, output command, output ack_index, input ready);
	modport sink (input valid, input command, input ack_index, output ready);
endinterface
`default_nettype wire

// ----- design/rcw_result_if.sv -----
// Result channel: send decision and window status
`default_nettype none
interface rcw_result_if;
	import rcw_pkg::*;
	logic valid;
	logic ready;
	logic send_valid;
	idx_t send_index;
	win_t window_size;
	thr_t threshold_halves;
	logic in_recovery;
	logic finished;

	modport source (output valid, output send_valid, output send_index, output window_size,
		output threshold_halves, output in_recovery, output finished, input ready);
	modport sink (input valid, input send_valid, input send_index, input window_size,
		input threshold_halves, input in_recovery, input finished, output ready);
endinterface
`default_nettype wire

// ----- design/reno_congestion_window.sv -----
// Reno congestion window controller: sequencer, state and result register
//
//  channel  dir  transfer when      payload
//  evt      in   valid && ready     command, ack_index
//  result   out  valid && ready     send_valid, send_index, window_size,
//                                   threshold_halves, in_recovery, finished
//  cfg      in   cfg_wr_en          cfg_index, cfg_data
//
// Send, timeout, duplicate ack and ignored events go from idle straight to emit;
// recovery entry and exit pass through clamp first. A new ack outside recovery
// goes through grow, clamp and emit; grow walks the packets it covers one per
// cycle through the shared growth unit (cut short once the window is pinned at
// its maximum outside avoidance). evt is not ready while an event is in progress;
// the result stage waits for a free result register. No clearing pass after reset.
`default_nettype none
`include "reno_congestion_window_assert.svh"
module reno_congestion_window (
	input  wire                               clk,
	input  wire                               arst_n,
	rcw_event_if.sink                         evt,
	rcw_result_if.source                      result,
	input  wire                               cfg_wr_en,
	input  wire [rcw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [rcw_pkg::CFG_W-1:0]          cfg_data
);
	import rcw_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_GROW  = 4'b0010,
		ST_CLAMP = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t     state_q;
	thr_t       thr_q;
	idx_t       fp_q;
	win_t       window_q;
	win_t       avoid_q;
	base_t      base_q;
	base_t      ls1_q;
	logic [1:0] dup_q;
	logic       rec_q;
	idx_t       cnt_q;
	base_t      pend_q;
	logic       sv_q;
	idx_t       sidx_q;
	logic       res_valid_q;

	step_req_t  step_req;
	step_rsp_t  step_rsp;
	base_t      tail_lim;
	logic       finished;

	logic       evt_fire;
	logic       emit_load;
	thr_t       dbl_win;
	logic       win_gt;
	logic       win_lt;
	logic       frozen;
	base_t      ack_ext;
	logic       ack_dup;
	logic       ack_new;
	logic [1:0] dup_inc;
	thr_t       halved;
	thr_t       entry_sum;
	win_t       entry_win;
	win_t       exit_win;
	base_t      clamp_lo;
	base_t      clamp_ls1;
	win_t       init_v;

	rcw_step_unit u_step (
		.req (step_req),
		.rsp (step_rsp)
	);

	rcw_tail_unit u_tail (
		.base         (base_q),
		.window       (window_q),
		.final_packet (fp_q),
		.tail_lim     (tail_lim),
		.finished     (finished)
	);

	always_comb begin
		evt_fire  = evt.valid && evt.ready;
		emit_load = (state_q == ST_EMIT) && (!res_valid_q || result.ready);
		dbl_win   = {window_q, 1'b0};
		win_gt    = dbl_win > thr_q;
		win_lt    = dbl_win < thr_q;
		frozen    = (window_q >= MAX_WIN) && !win_gt;

		step_req.window    = window_q;
		step_req.avoid     = avoid_q;
		step_req.use_avoid = (state_q == ST_GROW) ? win_gt : !win_lt;

		ack_ext = {1'b0, evt.ack_index};
		ack_dup = (ack_ext + 1'b1) == base_q;
		ack_new = (ack_ext >= base_q) && (ack_ext < ls1_q);
		dup_inc = (dup_q == DUP_LIMIT) ? dup_q : dup_q + 1'b1;

		halved    = halve_window(window_q);
		entry_sum = {1'b0, halved[THR_W-1:1]} + THR_W'(3);
		entry_win = (int'(entry_sum) > MAX_WINDOW) ? MAX_WIN : entry_sum[WIN_W-1:0];
		exit_win  = (thr_q[THR_W-1:1] == '0) ? WIN_W'(1) : thr_q[THR_W-1:1];

		// recovery entry only trims the sent mark down to the tail
		clamp_lo  = (!rec_q && (ls1_q < base_q)) ? base_q : ls1_q;
		clamp_ls1 = (clamp_lo > tail_lim) ? tail_lim : clamp_lo;

		init_v = (cfg_data[WIN_W-1:0] == '0) ? WIN_W'(1) : cfg_data[WIN_W-1:0];
	end

	assign evt.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			thr_q    <= START_THR;
			fp_q     <= '0;
			window_q <= WIN_W'(1);
			avoid_q  <= '0;
			base_q   <= '0;
			ls1_q    <= '0;
			dup_q    <= '0;
			rec_q    <= 1'b0;
			sv_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (evt_fire) begin
						sv_q    <= 1'b0;
						sidx_q  <= '0;
						state_q <= ST_EMIT;
						if (!finished) begin
							case (evt.command)
								CMD_SEND: begin
									if (ls1_q < tail_lim) begin
										ls1_q  <= ls1_q + 1'b1;
										sv_q   <= 1'b1;
										sidx_q <= ls1_q[IDX_W-1:0];
									end
								end
								CMD_ACK: begin
									if (ack_dup) begin
										dup_q <= dup_inc;
										if (rec_q) begin
											window_q <= step_rsp.window;
											avoid_q  <= step_rsp.avoid;
										end else if (dup_inc == DUP_LIMIT) begin
											thr_q    <= halved;
											window_q <= entry_win;
											avoid_q  <= '0;
											rec_q    <= 1'b1;
											sv_q     <= 1'b1;
											sidx_q   <= base_q[IDX_W-1:0];
											state_q  <= ST_CLAMP;
										end
									end else if (ack_new) begin
										dup_q <= '0;
										if (rec_q) begin
											window_q <= exit_win;
											rec_q    <= 1'b0;
											base_q   <= ack_ext + 1'b1;
											state_q  <= ST_CLAMP;
										end else begin
											cnt_q   <= evt.ack_index - base_q[IDX_W-1:0];
											pend_q  <= ack_ext + 1'b1;
											state_q <= ST_GROW;
										end
									end
								end
								CMD_TIMEOUT: begin
									thr_q    <= halved;
									window_q <= WIN_W'(1);
									ls1_q    <= base_q;
									dup_q    <= '0;
									avoid_q  <= '0;
									rec_q    <= 1'b0;
								end
								default: begin
								end
							endcase
						end
					end
				end
				ST_GROW: begin
					window_q <= step_rsp.window;
					avoid_q  <= step_rsp.avoid;
					if ((cnt_q == '0) || frozen) begin
						base_q  <= pend_q;
						state_q <= ST_CLAMP;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_CLAMP: begin
					ls1_q   <= clamp_ls1;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_wr_en) begin
				case (cfg_index)
					REG_INIT_THRESH: thr_q <= {init_v, 1'b0};
					REG_FINAL_PACKET: fp_q <= cfg_data[IDX_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			result.send_valid       <= sv_q;
			result.send_index       <= sidx_q;
			result.window_size      <= window_q;
			result.threshold_halves <= thr_q;
			result.in_recovery      <= rec_q;
			result.finished         <= finished;
		end
	end

	assign result.valid = res_valid_q;

	`RCW_ASSERT_NEXT(a_busy_after_accept, evt.valid && evt.ready, !evt.ready)
	`RCW_ASSERT_NEXT(a_result_held, result.valid && !result.ready, result.valid)
	`RCW_ASSERT_ALWAYS(a_window_thr_nonzero, (window_q != '0) && (thr_q != '0))
	`RCW_ASSERT_IMPL(a_recovery_dup_full, rec_q, dup_q == DUP_LIMIT)
endmodule
`default_nettype wire

// ----- design/rcw_step_unit.sv -----
// Shared window growth unit: one slow-start or avoidance step
`default_nettype none
module rcw_step_unit (
	input  rcw_pkg::step_req_t req,
	output rcw_pkg::step_rsp_t rsp
);
	import rcw_pkg::*;

	win_t avoid_inc;
	logic grow;

	always_comb begin
		avoid_inc = req.avoid + 1'b1;
		rsp.avoid = req.avoid;
		grow      = !req.use_avoid;
		if (req.use_avoid) begin
			if (avoid_inc >= req.window) begin
				grow      = 1'b1;
				rsp.avoid = '0;
			end else begin
				rsp.avoid = avoid_inc;
			end
		end
		rsp.window = (grow && (req.window < MAX_WIN)) ? req.window + 1'b1 : req.window;
	end
endmodule
`default_nettype wire

// ----- design/rcw_tail_unit.sv -----
// Window tail limit (one past the tail) and completion flag
`default_nettype none
module rcw_tail_unit (
	input  rcw_pkg::base_t base,
	input  rcw_pkg::win_t  window,
	input  rcw_pkg::idx_t  final_packet,
	output rcw_pkg::base_t tail_lim,
	output logic           finished
);
	import rcw_pkg::*;

	logic [BASE_W:0] span_end;
	base_t           fp_end;

	always_comb begin
		span_end = {1'b0, base} + (BASE_W + 1)'(window);
		fp_end   = {1'b0, final_packet} + 1'b1;
		tail_lim = (span_end > {1'b0, fp_end}) ? fp_end : span_end[BASE_W-1:0];
		finished = base > {1'b0, final_packet};
	end
endmodule
`default_nettype wire
